/* rtl/assert_macros.svh */
// Assertion helpers used by the pitch filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define ASSERT_SAME(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Next-cycle implication, muted during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

/* rtl/pcf_pkg.sv */
// ----------------------------------------------------------------------------
// pcf_pkg
// Constants, types and the CORDIC angle table of the pitch filter.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic signed [24:0] DEG180_Q16   = 25'sd11796480;
    localparam logic [24:0]        US_PER_SEC   = 25'd1000000;
    localparam logic [51:0]        HALF_SEC     = 52'd500000;

    localparam logic [15:0] GYRO_GAIN_RST  = 16'd1998;
    localparam logic [23:0] TAU_RST        = 24'd500000;
    localparam logic [19:0] MAX_INT_RST    = 20'd20000;

    localparam int DIV_W = 52;

    typedef enum logic [1:0] {
        REG_GYRO_GAIN = 2'd0,
        REG_TAU       = 2'd1,
        REG_MAX_INT   = 2'd2
    } reg_index_t;

    // atan(2^-i) in Q16 degrees
    function automatic logic [22:0] atan_deg(input logic [4:0] i);
        logic [22:0] r;
        case (i)
            5'd0:  r = 23'd2949120;
            5'd1:  r = 23'd1740967;
            5'd2:  r = 23'd919879;
            5'd3:  r = 23'd466945;
            5'd4:  r = 23'd234379;
            5'd5:  r = 23'd117304;
            5'd6:  r = 23'd58666;
            5'd7:  r = 23'd29335;
            5'd8:  r = 23'd14668;
            5'd9:  r = 23'd7334;
            5'd10: r = 23'd3667;
            5'd11: r = 23'd1833;
            5'd12: r = 23'd917;
            5'd13: r = 23'd458;
            5'd14: r = 23'd229;
            5'd15: r = 23'd115;
            5'd16: r = 23'd57;
            5'd17: r = 23'd29;
            5'd18: r = 23'd14;
            5'd19: r = 23'd7;
            5'd20: r = 23'd4;
            5'd21: r = 23'd2;
            5'd22: r = 23'd1;
            default: r = 23'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/pcf_if.sv */
// ----------------------------------------------------------------------------
// pcf_in_if / pcf_out_if
// Valid/ready channels for IMU samples and filter results.
// ----------------------------------------------------------------------------
interface pcf_in_if;
    logic               valid;
    logic               ready;
    logic               sample_valid;
    logic [47:0]        timestamp_us;
    logic signed [15:0] gyro_raw;
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;

    modport source (output valid, sample_valid, timestamp_us, gyro_raw,
                    accel_x_raw, accel_y_raw, accel_z_raw, input ready);
    modport sink   (input valid, sample_valid, timestamp_us, gyro_raw,
                    accel_x_raw, accel_y_raw, accel_z_raw, output ready);
endinterface

interface pcf_out_if;
    logic               valid;
    logic               ready;
    logic               estimate_valid;
    logic signed [24:0] pitch_q16;
    logic signed [31:0] rate_q16;
    logic [19:0]        interval_us;

    modport source (output valid, estimate_valid, pitch_q16, rate_q16, interval_us,
                    input ready);
    modport sink   (input valid, estimate_valid, pitch_q16, rate_q16, interval_us,
                    output ready);
endinterface

/* rtl/pcf_cordic.sv */
// ----------------------------------------------------------------------------
// pcf_cordic
// Iterative CORDIC vectoring unit: atan2(num, den) in Q16 degrees.
// ----------------------------------------------------------------------------
module pcf_cordic #(
    parameter int CORDIC_STEPS = pcf_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [16:0] num,
    input  logic signed [17:0] den,
    output logic               done,
    output logic signed [24:0] angle
);

    typedef enum logic [1:0] { C_IDLE, C_RUN, C_FIN } cstate_t;

    cstate_t            state_reg;
    logic [4:0]         iter_reg;
    logic signed [19:0] x_reg, y_reg;
    logic signed [25:0] z_reg;
    logic               done_reg;
    logic signed [24:0] angle_reg;

    logic signed [19:0] xs, ys;
    logic signed [25:0] at;

    assign xs = x_reg >>> iter_reg;
    assign ys = y_reg >>> iter_reg;
    assign at = 26'(signed'({1'b0, pcf_pkg::atan_deg(iter_reg)}));

    assign done  = done_reg;
    assign angle = angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        iter_reg <= '0;
                        if (num == 0)
                        begin
                            angle_reg <= (den >= 0) ? 25'sd0 : pcf_pkg::DEG180_Q16;
                            done_reg  <= 1'b1;
                        end
                        else if (den < 0)
                        begin
                            x_reg     <= 20'(-den);
                            y_reg     <= 20'(-num);
                            z_reg     <= (num > 0) ? 26'(pcf_pkg::DEG180_Q16)
                                                   : 26'(-pcf_pkg::DEG180_Q16);
                            state_reg <= C_RUN;
                        end
                        else
                        begin
                            x_reg     <= 20'(den);
                            y_reg     <= 20'(num);
                            z_reg     <= '0;
                            state_reg <= C_RUN;
                        end
                    end
                end
                C_RUN:
                begin
                    if (y_reg > 0)
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end
                    if (iter_reg == 5'(CORDIC_STEPS - 1))
                        state_reg <= C_FIN;
                    else
                        iter_reg <= iter_reg + 5'd1;
                end
                C_FIN:
                begin
                    if (z_reg > 26'(pcf_pkg::DEG180_Q16))
                        angle_reg <= pcf_pkg::DEG180_Q16;
                    else if (z_reg < 26'(-pcf_pkg::DEG180_Q16))
                        angle_reg <= -pcf_pkg::DEG180_Q16;
                    else
                        angle_reg <= z_reg[24:0];
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

endmodule

/* rtl/pcf_divider.sv */
// ----------------------------------------------------------------------------
// pcf_divider
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module pcf_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pcf_pkg::DIV_W-1:0] dividend,
    input  logic [24:0]               divisor,
    output logic                      done,
    output logic [pcf_pkg::DIV_W-1:0] quotient
);

    localparam int CW = $clog2(pcf_pkg::DIV_W + 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CW-1:0]             cnt_reg;
    logic [24:0]               rem_reg;
    logic [24:0]               dsr_reg;
    logic [pcf_pkg::DIV_W-1:0] q_reg;

    logic [25:0] trial;
    logic        fits;

    assign trial = {rem_reg, q_reg[pcf_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                q_reg    <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? 25'(trial - {1'b0, dsr_reg}) : trial[24:0];
                q_reg   <= {q_reg[pcf_pkg::DIV_W-2:0], fits};
                if (cnt_reg == CW'(pcf_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

endmodule

/* rtl/pitch_complementary_filter.sv */
// ----------------------------------------------------------------------------
// pitch_complementary_filter
// Complementary pitch filter: gyro integration blended with accel pitch.
// ----------------------------------------------------------------------------
// One sample at a time. An invalid sample goes straight to the output; a
// first or rejected sample leaves after the CORDIC. For a blended sample
// the alpha divide sets the pace, and the gyro step (divide by one million
// by reciprocal multiply, 13 bits per chunk) runs beside it. With accel x
// zero the CORDIC finishes at once and skips its iterations. The result
// waits in an output register, so the sample port opens again while the
// result is still pending; a result that finds that register full holds
// the block until the earlier one is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pitch_complementary_filter #(
    parameter int CORDIC_STEPS  = pcf_pkg::CORDIC_STEPS_DEF,
    parameter int FRACTION_BITS = pcf_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pcf_in_if.sink      sample_ch,
    pcf_out_if.source   estimate_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam logic signed [21:0] ONE  = 22'(64'sd1 <<< FRACTION_BITS);
    localparam logic signed [58:0] HALF = 59'(64'sd1 <<< (FRACTION_BITS - 1));
    // floor(2^34 / 10^6); estimate is low by at most one
    localparam logic signed [21:0] RECIP_US = 22'sd17179;
    localparam logic signed [21:0] US_MUL   = 22'sd1000000;

    typedef enum logic [3:0] {
        S_IDLE, S_RATE, S_CSTART, S_CWAIT, S_PROD, S_PSTART, S_Q1, S_Q2, S_Q3,
        S_INTEG, S_AWAIT, S_M1, S_M2, S_M3, S_OUT
    } state_t;

    state_t state_reg;

    logic [15:0] gain_reg;
    logic [23:0] tau_reg;
    logic [19:0] max_reg;

    logic signed [24:0] pitch_reg;
    logic [47:0]        last_reg;

    logic [47:0]        ts_reg;
    logic signed [15:0] gyro_reg, ax_reg, ay_reg, az_reg;
    logic signed [31:0] rate_reg;
    logic signed [25:0] acc_reg;
    logic [19:0]        elapsed_reg;
    logic               neg_reg;
    logic signed [34:0] integ_reg;
    logic signed [21:0] alpha_reg;
    logic signed [58:0] sum_reg;

    // gyro step: chunked divide by one million
    logic [51:0]        num_reg;
    logic [51:0]        quot_reg;
    logic [19:0]        crem_reg;
    logic [12:0]        qe_reg;
    logic [1:0]         chunk_reg;

    logic               res_ev_reg;
    logic signed [24:0] res_pitch_reg;
    logic [19:0]        res_int_reg;

    logic               out_valid_reg;
    logic               out_ev_reg;
    logic signed [24:0] out_pitch_reg;
    logic signed [31:0] out_rate_reg;
    logic [19:0]        out_int_reg;

    // shared multiplier, product registered
    logic signed [35:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [57:0] prod_reg;

    logic               cor_start, cor_done;
    logic signed [24:0] cor_angle;
    logic               div_start, div_done;
    logic [51:0]        div_dividend, div_q;
    logic [24:0]        div_divisor;

    logic signed [48:0] diff;
    logic [24:0]        den_a;
    logic signed [17:0] cden;
    logic signed [16:0] ay_abs;
    logic [57:0]        mag;
    logic signed [33:0] step;
    logic signed [58:0] fsum;
    logic signed [58:0] fsh;
    logic [32:0]        chunk_t;
    logic [32:0]        chunk_r;
    logic               chunk_fix;

    assign diff  = signed'({1'b0, ts_reg}) - signed'({1'b0, last_reg});
    assign den_a = {1'b0, tau_reg} + {5'b0, elapsed_reg};
    assign ay_abs = (ay_reg < 0) ? -17'(ay_reg) : 17'(ay_reg);
    assign cden  = 18'(az_reg) + 18'(ay_abs);
    assign mag   = prod_reg[57] ? 58'(-prod_reg) : 58'(prod_reg);
    assign step  = neg_reg ? -signed'({1'b0, quot_reg[32:0]})
                           : signed'({1'b0, quot_reg[32:0]});
    assign fsum  = sum_reg + 59'(prod_reg) + HALF;
    assign fsh   = fsum >>> FRACTION_BITS;

    assign chunk_t   = {crem_reg, num_reg[51:39]};
    assign chunk_r   = chunk_t - prod_reg[32:0];
    assign chunk_fix = chunk_r >= 33'(pcf_pkg::US_PER_SEC);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_RATE:
            begin
                mul_a = 36'(gyro_reg);
                mul_b = 22'(signed'({1'b0, gain_reg}));
            end
            S_PROD:
            begin
                mul_a = 36'(rate_reg);
                mul_b = 22'(signed'({1'b0, elapsed_reg}));
            end
            S_Q1:
            begin
                mul_a = 36'(signed'({1'b0, chunk_t}));
                mul_b = RECIP_US;
            end
            S_Q2:
            begin
                mul_a = 36'(signed'({1'b0, prod_reg[46:34]}));
                mul_b = US_MUL;
            end
            S_M1:
            begin
                mul_a = 36'(integ_reg);
                mul_b = alpha_reg;
            end
            S_M2:
            begin
                mul_a = 36'(acc_reg);
                mul_b = ONE - alpha_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
        prod_reg <= mul_a * mul_b;

    assign cor_start    = (state_reg == S_CSTART);
    assign div_start    = (state_reg == S_PSTART);
    assign div_dividend = (52'(tau_reg) << FRACTION_BITS) + 52'(den_a >> 1);
    assign div_divisor  = den_a;

    pcf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .num   (17'(ax_reg)),
        .den   (cden),
        .done  (cor_done),
        .angle (cor_angle)
    );

    pcf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sample_ch.ready          = (state_reg == S_IDLE);
    assign estimate_ch.valid        = out_valid_reg;
    assign estimate_ch.estimate_valid = out_ev_reg;
    assign estimate_ch.pitch_q16    = out_pitch_reg;
    assign estimate_ch.rate_q16     = out_rate_reg;
    assign estimate_ch.interval_us  = out_int_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_reg      <= pcf_pkg::GYRO_GAIN_RST;
            tau_reg       <= pcf_pkg::TAU_RST;
            max_reg       <= pcf_pkg::MAX_INT_RST;
            pitch_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pcf_pkg::REG_GYRO_GAIN: gain_reg <= cfg_data[15:0];
                    pcf_pkg::REG_TAU:       tau_reg  <= cfg_data;
                    pcf_pkg::REG_MAX_INT:   max_reg  <= cfg_data[19:0];
                    default: ;
                endcase
            end

            // S_OUT reloads the register itself when the beat is taken
            if (estimate_ch.valid && estimate_ch.ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (sample_ch.valid)
                    begin
                        ts_reg        <= sample_ch.timestamp_us;
                        gyro_reg      <= sample_ch.gyro_raw;
                        ax_reg        <= sample_ch.accel_x_raw;
                        ay_reg        <= sample_ch.accel_y_raw;
                        az_reg        <= sample_ch.accel_z_raw;
                        rate_reg      <= '0;
                        res_ev_reg    <= 1'b0;
                        res_pitch_reg <= '0;
                        res_int_reg   <= '0;
                        state_reg     <= sample_ch.sample_valid ? S_RATE : S_OUT;
                    end
                end
                S_RATE:   state_reg <= S_CSTART;
                S_CSTART:
                begin
                    if (prod_reg > 58'sd2147483647)
                        rate_reg <= 32'sh7FFFFFFF;
                    else if (prod_reg < -58'sd2147483648)
                        rate_reg <= 32'sh80000000;
                    else
                        rate_reg <= prod_reg[31:0];
                    state_reg <= S_CWAIT;
                end
                S_CWAIT:
                begin
                    if (cor_done)
                    begin
                        acc_reg <= -26'(cor_angle);
                        if (last_reg == 48'd0)
                        begin
                            pitch_reg     <= -cor_angle;
                            last_reg      <= ts_reg;
                            res_ev_reg    <= 1'b1;
                            res_pitch_reg <= -cor_angle;
                            state_reg     <= S_OUT;
                        end
                        else if (diff[48] || diff == 49'sd0 ||
                                 diff > signed'(49'(max_reg)))
                        begin
                            rate_reg  <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            elapsed_reg <= diff[19:0];
                            state_reg   <= S_PROD;
                        end
                    end
                end
                S_PROD:   state_reg <= S_PSTART;
                S_PSTART:
                begin
                    neg_reg   <= prod_reg[57];
                    num_reg   <= mag[51:0] + pcf_pkg::HALF_SEC;
                    crem_reg  <= '0;
                    chunk_reg <= '0;
                    state_reg <= S_Q1;
                end
                S_Q1:     state_reg <= S_Q2;
                S_Q2:
                begin
                    qe_reg    <= prod_reg[46:34];
                    state_reg <= S_Q3;
                end
                S_Q3:
                begin
                    crem_reg <= chunk_fix ? 20'(chunk_r - 33'(pcf_pkg::US_PER_SEC))
                                          : chunk_r[19:0];
                    quot_reg <= {quot_reg[38:0], qe_reg + 13'(chunk_fix)};
                    num_reg  <= {num_reg[38:0], 13'd0};
                    if (chunk_reg == 2'd3)
                        state_reg <= S_INTEG;
                    else
                    begin
                        chunk_reg <= chunk_reg + 2'd1;
                        state_reg <= S_Q1;
                    end
                end
                S_INTEG:
                begin
                    integ_reg <= 35'(pitch_reg) + 35'(step);
                    state_reg <= S_AWAIT;
                end
                S_AWAIT:
                begin
                    if (div_done)
                    begin
                        alpha_reg <= 22'(div_q[20:0]);
                        state_reg <= S_M1;
                    end
                end
                S_M1:     state_reg <= S_M2;
                S_M2:
                begin
                    sum_reg   <= 59'(prod_reg);
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    if (fsh > 59'(pcf_pkg::DEG180_Q16))
                        pitch_reg <= pcf_pkg::DEG180_Q16;
                    else if (fsh < 59'(-pcf_pkg::DEG180_Q16))
                        pitch_reg <= -pcf_pkg::DEG180_Q16;
                    else
                        pitch_reg <= fsh[24:0];
                    if (fsh > 59'(pcf_pkg::DEG180_Q16))
                        res_pitch_reg <= pcf_pkg::DEG180_Q16;
                    else if (fsh < 59'(-pcf_pkg::DEG180_Q16))
                        res_pitch_reg <= -pcf_pkg::DEG180_Q16;
                    else
                        res_pitch_reg <= fsh[24:0];
                    last_reg    <= ts_reg;
                    res_ev_reg  <= 1'b1;
                    res_int_reg <= elapsed_reg;
                    state_reg   <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || estimate_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ev_reg    <= res_ev_reg;
                        out_pitch_reg <= res_pitch_reg;
                        out_rate_reg  <= res_ev_reg ? rate_reg : 32'sd0;
                        out_int_reg   <= res_int_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_busy_after_beat, clk, rst_n, sample_ch.valid && sample_ch.ready,
                 !sample_ch.ready)
    `ASSERT_SAME(a_pitch_range, clk, rst_n, 1'b1,
                 pitch_reg <= pcf_pkg::DEG180_Q16 && pitch_reg >= -pcf_pkg::DEG180_Q16)
    `ASSERT_SAME(a_zero_result, clk, rst_n,
                 estimate_ch.valid && !estimate_ch.estimate_valid,
                 estimate_ch.pitch_q16 == 0 && estimate_ch.rate_q16 == 0 &&
                 estimate_ch.interval_us == 0)

endmodule

/* tb/pcf_checker.sv */
// ----------------------------------------------------------------------------
// pcf_checker
// Watches the sample, estimate and register ports of the pitch filter, keeps
// its own copy of the filter state, predicts every estimate and compares.
// ----------------------------------------------------------------------------
module pcf_checker (
    input  logic        clk,
    input  logic        rst_n,
    pcf_in_if           sample_ch,
    pcf_out_if          estimate_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam longint HALF_TURN = 64'sd11796480;
    localparam longint ONE_Q16   = 64'sd65536;
    localparam longint ANGLE_Q16 [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct {
        logic               ok;
        logic signed [24:0] pitch;
        logic signed [31:0] rate;
        logic [19:0]        gap;
    } estimate_t;

    estimate_t   estimate_q[$];
    logic [15:0] gain;
    logic [23:0] tau;
    logic [19:0] gap_limit;
    longint      pitch_state;
    logic [47:0] last_ts;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // atan2(num, den) in Q16 degrees, vectoring mode
    function automatic longint tilt_angle(longint num, longint den);
        longint xc, yc, z, xs, ys;
        xc = den;
        yc = num;
        z  = 0;
        if (num == 0)
            return den >= 0 ? 0 : HALF_TURN;
        if (den < 0)
        begin
            z  = num > 0 ? HALF_TURN : -HALF_TURN;
            xc = -den;
            yc = -num;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = xc >>> i;
            ys = yc >>> i;
            if (yc > 0)
            begin
                xc += ys; yc -= xs; z += ANGLE_Q16[i];
            end
            else
            begin
                xc -= ys; yc += xs; z -= ANGLE_Q16[i];
            end
        end
        return clip(z, -HALF_TURN, HALF_TURN);
    endfunction

    function automatic estimate_t filter_sample();
        estimate_t e;
        longint rate, acc, elapsed, prod, mag, stp, integ, alpha, sum, ay;
        e = '{ok: 1'b0, pitch: '0, rate: '0, gap: '0};
        elapsed = 0;
        if (!sample_ch.sample_valid)
            return e;
        rate = clip(longint'(sample_ch.gyro_raw) * longint'(gain),
                    -64'sd2147483648, 64'sd2147483647);
        ay  = longint'(sample_ch.accel_y_raw);
        acc = -tilt_angle(longint'(sample_ch.accel_x_raw),
                          longint'(sample_ch.accel_z_raw) + (ay < 0 ? -ay : ay));
        if (last_ts == 0)
            pitch_state = acc;
        else
        begin
            elapsed = longint'({16'd0, sample_ch.timestamp_us}) - longint'({16'd0, last_ts});
            if (elapsed <= 0 || elapsed > longint'(gap_limit))
                return e;
            prod  = rate * elapsed;
            mag   = prod < 0 ? -prod : prod;
            stp   = (mag + 500000) / 1000000;
            if (prod < 0)
                stp = -stp;
            integ = pitch_state + stp;
            alpha = ((longint'(tau) <<< 16) + (longint'(tau) + elapsed) / 2)
                    / (longint'(tau) + elapsed);
            sum   = alpha * integ + (ONE_Q16 - alpha) * acc;
            sum   = (sum + ONE_Q16 / 2) >>> 16;
            pitch_state = clip(sum, -HALF_TURN, HALF_TURN);
        end
        last_ts = sample_ch.timestamp_us;
        e.ok    = 1'b1;
        e.pitch = pitch_state[24:0];
        e.rate  = rate[31:0];
        e.gap   = elapsed[19:0];
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        estimate_t want;
        if (!rst_n)
        begin
            gain        <= pcf_pkg::GYRO_GAIN_RST;
            tau         <= pcf_pkg::TAU_RST;
            gap_limit   <= pcf_pkg::MAX_INT_RST;
            pitch_state = 0;
            last_ts     = '0;
            estimate_q.delete();
            errors      <= 0;
            pending     <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (pcf_pkg::reg_index_t'(cfg_index))
                    pcf_pkg::REG_GYRO_GAIN: gain      <= cfg_data[15:0];
                    pcf_pkg::REG_TAU:       tau       <= cfg_data;
                    pcf_pkg::REG_MAX_INT:   gap_limit <= cfg_data[19:0];
                    default: ;
                endcase
            end
            if (sample_ch.valid && sample_ch.ready)
                estimate_q.push_back(filter_sample());
            if (estimate_ch.valid && estimate_ch.ready)
            begin
                if (estimate_q.size() == 0)
                begin
                    $error("estimate beat with nothing expected");
                    errors <= errors + 1;
                end
                else
                begin
                    want = estimate_q.pop_front();
                    if (estimate_ch.estimate_valid !== want.ok
                        || estimate_ch.pitch_q16 !== want.pitch
                        || estimate_ch.rate_q16 !== want.rate
                        || estimate_ch.interval_us !== want.gap)
                        errors <= errors + 1;
                    if (estimate_ch.estimate_valid !== want.ok)
                        $error("estimate_valid expected %0d actual %0d",
                               want.ok, estimate_ch.estimate_valid);
                    if (estimate_ch.pitch_q16 !== want.pitch)
                        $error("pitch_q16 expected %0d actual %0d",
                               want.pitch, estimate_ch.pitch_q16);
                    if (estimate_ch.rate_q16 !== want.rate)
                        $error("rate_q16 expected %0d actual %0d",
                               want.rate, estimate_ch.rate_q16);
                    if (estimate_ch.interval_us !== want.gap)
                        $error("interval_us expected %0d actual %0d",
                               want.gap, estimate_ch.interval_us);
                end
            end
            pending <= estimate_q.size();
        end
    end
endmodule

/* tb/pitch_complementary_filter_tb.sv */
// ----------------------------------------------------------------------------
// pitch_complementary_filter_tb
// Drives IMU samples and register settings into the pitch filter under random
// flow control; the checker predicts and compares each estimate.
// ----------------------------------------------------------------------------
module pitch_complementary_filter_tb;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    int          errors;
    int          pending;
    int          send_idle;
    int          recv_idle;
    bit          hold_req;
    bit          held;
    logic [47:0] base_ts;
    logic [19:0] cur_limit;

    pcf_in_if  sample_ch ();
    pcf_out_if estimate_ch ();

    pitch_complementary_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (sample_ch),
        .estimate_ch(estimate_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    pcf_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (sample_ch),
        .estimate_ch(estimate_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        estimate_ch.ready = 1'b0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                repeat (400)
                begin
                    estimate_ch.ready = 1'b0;
                    @(negedge clk);
                end
            end
            estimate_ch.ready = ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_sample(input logic sv, input logic [47:0] ts,
                               input logic [15:0] g, input logic [15:0] ax,
                               input logic [15:0] ay, input logic [15:0] az);
        while ($urandom_range(99) < send_idle)
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid        = 1'b1;
        sample_ch.sample_valid = sv;
        sample_ch.timestamp_us = ts;
        sample_ch.gyro_raw     = g;
        sample_ch.accel_x_raw  = ax;
        sample_ch.accel_y_raw  = ay;
        sample_ch.accel_z_raw  = az;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sample_ch.valid = 1'b0;
    endtask

    task automatic write_reg(input pcf_pkg::reg_index_t idx, input logic [23:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic settle();
        while (pending != 0 || sample_ch.valid)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic set_filter(input logic [15:0] gain, input logic [23:0] tau,
                              input logic [19:0] limit);
        settle();
        write_reg(pcf_pkg::REG_GYRO_GAIN, {8'd0, gain});
        write_reg(pcf_pkg::REG_TAU, tau);
        write_reg(pcf_pkg::REG_MAX_INT, {4'd0, limit});
        cur_limit = limit;
    endtask

    // mostly well-formed timestamp runs, with invalid, restart and bad-gap noise
    task automatic random_sample();
        int          kind;
        logic [47:0] ts;
        logic [15:0] ax;
        logic [19:0] span;
        kind = $urandom_range(99);
        span = (cur_limit == 0) ? 20'd1 : cur_limit;
        ax   = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
        if (kind < 5)
            ts = {$urandom, $urandom};
        else if (kind < 8)
            ts = '0;
        else if (kind < 12)
            ts = base_ts - $urandom_range(0, 1000);
        else if (kind < 16)
            ts = base_ts + span + $urandom_range(1, 5000);
        else if (kind < 18)
            ts = {$urandom, $urandom};
        else
            ts = base_ts + $urandom_range(1, span);
        if (kind >= 5 && (kind < 8 || kind >= 16))
            base_ts = ts;
        send_sample(kind >= 5, ts, 16'($urandom), ax, 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        sample_ch.valid        = 1'b0;
        sample_ch.sample_valid = 1'b0;
        sample_ch.timestamp_us = '0;
        sample_ch.gyro_raw     = '0;
        sample_ch.accel_x_raw  = '0;
        sample_ch.accel_y_raw  = '0;
        sample_ch.accel_z_raw  = '0;
        cfg_we    = 1'b0;
        cfg_index = pcf_pkg::REG_GYRO_GAIN;
        cfg_data  = '0;
        hold_req  = 1'b0;
        send_idle = 25;
        recv_idle = 59;
        cur_limit = pcf_pkg::MAX_INT_RST;
        base_ts   = '0;
        rst_n     = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings
        send_sample(1'b0, 48'hFFFF_FFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_sample(1'b1, 48'd1000, 16'sh7FFF, 16'd0, 16'd0, 16'h8000);   // x=0, den<0
        send_sample(1'b1, 48'd2000, 16'sh8000, 16'd0, 16'd5, 16'd7);      // x=0, den>=0
        send_sample(1'b1, 48'd2000, 16'd100, 16'd300, 16'd10, 16'd400);   // zero gap
        send_sample(1'b1, 48'd1500, 16'd100, 16'd300, 16'd10, 16'd400);   // backward
        send_sample(1'b1, 48'd22001, 16'd100, 16'd300, 16'd10, 16'd400);  // too long
        send_sample(1'b1, 48'd22000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000); // max gap
        send_sample(1'b1, 48'd22001, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
        send_sample(1'b1, 48'd30000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_sample(1'b1, 48'd0, 16'd5, 16'hFFFF, 16'd0, 16'd1);          // zero stamp
        send_sample(1'b1, 48'hFFFF_FFFF_FFF0, 16'd5, 16'd1, 16'd0, 16'hFFFF);
        send_sample(1'b1, 48'hFFFF_FFFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_sample(1'b1, 48'h0000_0000_0010, 16'd1, 16'd1, 16'd1, 16'd1); // wrap
        base_ts = 48'hFFFF_FFFF_FFFF;

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1: set_filter(16'hFFFF, 24'd1, 20'd1000000);
                2: set_filter(16'd1, 24'd10000000, 20'd1);
                3: set_filter(16'd0, 24'd0, 20'd0);
                4: set_filter(16'd40000, 24'hFFFFFF, 20'hFFFFF);
                5: set_filter(pcf_pkg::GYRO_GAIN_RST, pcf_pkg::TAU_RST,
                              pcf_pkg::MAX_INT_RST);
                default: ;
            endcase
            send_idle = (phase < 2) ? 25 : (phase < 4) ? 59 : 0;
            recv_idle = (phase < 2) ? 59 : (phase < 4) ? 25 : 0;
            if (phase == 4)
                hold_req = 1'b1;
            repeat (206) random_sample();
        end

        settle();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/pcf_pkg.sv
rtl/pcf_if.sv
rtl/pcf_cordic.sv
rtl/pcf_divider.sv
rtl/pitch_complementary_filter.sv
tb/pcf_checker.sv
tb/pitch_complementary_filter_tb.sv
